/* hw/rtl/glcd_dirty_refresh_scanner_macros.svh */
// ---------------------------------------------------------------------------
// glcd assertion macros
// concurrent assertion helpers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef GLCD_DIRTY_REFRESH_SCANNER_MACROS_SVH
`define GLCD_DIRTY_REFRESH_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GLCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glcd assertion failed");
// next-cycle implication
`define GLCD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glcd assertion failed");
`else
`define GLCD_ASSERT_IMP(label, ante, cons)
`define GLCD_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* hw/rtl/glcd_pkg.sv */
// ---------------------------------------------------------------------------
// glcd package
// request and result types, codes and lcd command bytes of the refresh engine
// ---------------------------------------------------------------------------
package glcd_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] byte_index;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic       select1_n;
    logic       select2_n;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last_of_scan;
  } out_item_t;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;

  localparam logic [2:0] OUT_ACCEPTED = 3'd0;
  localparam logic [2:0] OUT_REFUSED  = 3'd1;
  localparam logic [2:0] OUT_XFER     = 3'd2;
  localparam logic [2:0] OUT_STARTED  = 3'd3;
  localparam logic [2:0] OUT_NOTHING  = 3'd4;

  localparam logic [7:0] CMD_PAGE  = 8'hB8;
  localparam logic [7:0] CMD_START = 8'hC0;
  localparam logic [7:0] CMD_ADDR  = 8'h40;

  // result with no bus transfer: selects deasserted, rest zero
  function automatic out_item_t idle_result(input logic [2:0] outcome);
    out_item_t r;
    r.outcome      = outcome;
    r.select1_n    = 1'b1;
    r.select2_n    = 1'b1;
    r.is_data      = 1'b0;
    r.bus_byte     = 8'd0;
    r.last_of_scan = 1'b0;
    return r;
  endfunction

endpackage

/* hw/rtl/glcd_stream_if.sv */
// ---------------------------------------------------------------------------
// glcd stream interfaces
// valid/ready channels for requests and results of the refresh engine
// ---------------------------------------------------------------------------
interface glcd_in_if;
  import glcd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface glcd_out_if;
  import glcd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/glcd_ram.sv */
// ---------------------------------------------------------------------------
// glcd ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module glcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/glcd_dirty_refresh_scanner.sv */
// ---------------------------------------------------------------------------
// glcd dirty refresh scanner
// framebuffer, shadow copy and refresh sequencer for a multi-controller lcd
// ---------------------------------------------------------------------------
// Requests are taken one at a time. A request is taken only in the idle state;
// its result then goes to an output register that holds it until the sink
// takes it, so the next request can be taken while that result waits.
// Refresh requests, command transfers, idle ticks, refused writes and unknown
// kinds pass through the result state straight back to idle; a framebuffer write
// adds a write-update state (read of frame and shadow, then write-back and count
// update); a column-byte transfer adds a gather state that issues eight reads of
// vertically stacked framebuffer bytes through the single read port of the frame
// and shadow memories. After reset a clearing pass zeroes both memories, one
// entry a cycle, ROW_BYTES*PAGE_COUNT*8 entries (1024 at the defaults); no request
// is taken during it, configuration writes are.
`include "glcd_dirty_refresh_scanner_macros.svh"

module glcd_dirty_refresh_scanner #(
  parameter int CONTROLLER_COUNT       = 2,
  parameter int PAGE_COUNT             = 8,
  parameter int COLUMNS_PER_CONTROLLER = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  glcd_in_if.sink    in_req,
  glcd_out_if.source out_rsp
);
  import glcd_pkg::*;

  // framebuffer geometry
  localparam int ROW_BYTES   = (CONTROLLER_COUNT * COLUMNS_PER_CONTROLLER) / 8;
  localparam int FB_SIZE     = ROW_BYTES * PAGE_COUNT * 8;
  localparam int CTRL_BYTES  = COLUMNS_PER_CONTROLLER / 8;
  localparam int PAGE_STRIDE = ROW_BYTES * 8;
  localparam int AW          = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1;
  // gather address may run past the framebuffer, keep headroom
  localparam int IDXW        = AW + 2;
  localparam int DCW         = $clog2(FB_SIZE + 1);
  localparam int CIW         = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;
  localparam int PGW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int STW         = $clog2(COLUMNS_PER_CONTROLLER + 4);
  localparam int COLW        = $clog2(COLUMNS_PER_CONTROLLER);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WR_UPD = 3'd2;
  localparam logic [2:0] ST_GATHER = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            refresh_enable_r, refresh_enable_nxt;

  // scan position
  logic            scanning_r, scanning_nxt;
  logic [CIW-1:0]  ci_r, ci_nxt;
  logic [PGW-1:0]  page_r, page_nxt;
  logic [STW-1:0]  step_r, step_nxt;
  logic            lead_r, lead_nxt;
  logic [DCW-1:0]  differ_r, differ_nxt;

  // write in flight
  logic [AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [7:0]      wr_val_r, wr_val_nxt;

  // column gather: issue counter, running address, read pipeline stage
  logic [3:0]      g_cnt_r, g_cnt_nxt;
  logic [IDXW-1:0] g_addr_r, g_addr_nxt;
  logic [2:0]      col_lo_r, col_lo_nxt;
  logic [7:0]      acc_r, acc_nxt;
  logic            p_vld_r, p_vld_nxt;
  logic [2:0]      p_b_r, p_b_nxt;
  logic [AW-1:0]   p_addr_r, p_addr_nxt;

  // pending result and output register
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic            out_load;

  // memory ports
  logic            fb_we, sh_we;
  logic [AW-1:0]   fb_waddr, sh_waddr, rd_addr;
  logic [7:0]      fb_wdata, sh_wdata, fb_q, sh_q;

  glcd_ram #(.WIDTH(8), .DEPTH(FB_SIZE)) u_frame (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (rd_addr),
    .rdata (fb_q)
  );

  glcd_ram #(.WIDTH(8), .DEPTH(FB_SIZE)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .raddr (rd_addr),
    .rdata (sh_q)
  );

  assign in_req.ready    = (state_r == ST_IDLE);
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = out_item_r;

  assign refresh_enable_nxt = cfg_we ? cfg_wdata : refresh_enable_r;

  always_comb begin
    logic [COLW-1:0] col_v;
    logic [IDXW-1:0] base_v;
    logic [7:0]      acc_v;
    logic            was_v;
    logic            now_v;

    state_nxt    = state_r;
    clr_nxt      = clr_r;
    scanning_nxt = scanning_r;
    ci_nxt       = ci_r;
    page_nxt     = page_r;
    step_nxt     = step_r;
    lead_nxt     = lead_r;
    differ_nxt   = differ_r;
    wr_idx_nxt   = wr_idx_r;
    wr_val_nxt   = wr_val_r;
    g_cnt_nxt    = g_cnt_r;
    g_addr_nxt   = g_addr_r;
    col_lo_nxt   = col_lo_r;
    acc_nxt      = acc_r;
    p_vld_nxt    = 1'b0;
    p_b_nxt      = p_b_r;
    p_addr_nxt   = p_addr_r;
    res_nxt      = res_r;
    out_load     = 1'b0;

    fb_we    = 1'b0;
    fb_waddr = wr_idx_r;
    fb_wdata = wr_val_r;
    sh_we    = 1'b0;
    sh_waddr = p_addr_r;
    sh_wdata = fb_q;
    rd_addr  = AW'(in_req.payload.byte_index);

    // column of the current step and its first framebuffer byte
    col_v  = COLW'(step_r - STW'(4));
    base_v = IDXW'(ci_r) * IDXW'(CTRL_BYTES) + IDXW'(col_v >> 3)
           + IDXW'(page_r) * IDXW'(PAGE_STRIDE);
    acc_v  = acc_r;
    was_v  = (fb_q != sh_q);
    now_v  = (wr_val_r != sh_q);

    unique case (state_r)
      ST_CLEAR: begin
        // zero both memories after reset
        fb_we    = 1'b1;
        sh_we    = 1'b1;
        fb_waddr = clr_r;
        sh_waddr = clr_r;
        fb_wdata = 8'd0;
        sh_wdata = 8'd0;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(FB_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_RESULT;
          res_nxt   = idle_result(OUT_NOTHING);
          unique case (in_req.payload.kind)
            KIND_WRITE: begin
              if (scanning_r) begin
                res_nxt = idle_result(OUT_REFUSED);
              end else if (32'(in_req.payload.byte_index) < FB_SIZE) begin
                // frame and shadow entries are read this cycle
                wr_idx_nxt = AW'(in_req.payload.byte_index);
                wr_val_nxt = in_req.payload.write_value;
                state_nxt  = ST_WR_UPD;
              end
            end
            KIND_REQUEST: begin
              if (!scanning_r && refresh_enable_r && (differ_r != DCW'(0))) begin
                scanning_nxt = 1'b1;
                ci_nxt       = CIW'(0);
                page_nxt     = PGW'(0);
                step_nxt     = STW'(0);
                lead_nxt     = 1'b0;
                res_nxt      = idle_result(OUT_STARTED);
              end
            end
            KIND_TICK: begin
              if (scanning_r) begin
                res_nxt.outcome      = OUT_XFER;
                res_nxt.select1_n    = !(ci_r == CIW'(0));
                res_nxt.select2_n    = !(CONTROLLER_COUNT > 1 && ci_r == CIW'(1));
                res_nxt.is_data      = 1'b0;
                res_nxt.last_of_scan = 1'b0;
                if (!lead_r) begin
                  // startline no-op ahead of each controller
                  res_nxt.bus_byte = CMD_START;
                  lead_nxt         = 1'b1;
                end else if (step_r == STW'(0)) begin
                  res_nxt.bus_byte = CMD_PAGE | 8'(page_r);
                  step_nxt         = step_r + STW'(1);
                end else if (step_r == STW'(1) || step_r == STW'(3)) begin
                  res_nxt.bus_byte = CMD_START;
                  step_nxt         = step_r + STW'(1);
                end else if (step_r == STW'(2)) begin
                  res_nxt.bus_byte = CMD_ADDR;
                  step_nxt         = step_r + STW'(1);
                end else begin
                  // column byte: gather eight stacked bytes
                  state_nxt  = ST_GATHER;
                  g_cnt_nxt  = 4'd0;
                  g_addr_nxt = base_v;
                  col_lo_nxt = col_v[2:0];
                  acc_nxt    = 8'd0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WR_UPD: begin
        fb_we   = 1'b1;
        res_nxt = idle_result(OUT_ACCEPTED);
        if (was_v && !now_v && (differ_r != DCW'(0))) begin
          differ_nxt = differ_r - DCW'(1);
        end else if (!was_v && now_v) begin
          differ_nxt = differ_r + DCW'(1);
        end
        state_nxt = ST_RESULT;
      end

      ST_GATHER: begin
        rd_addr = g_addr_r[AW-1:0];
        if (g_cnt_r != 4'd8) begin
          p_vld_nxt  = (g_addr_r < IDXW'(FB_SIZE));
          p_b_nxt    = g_cnt_r[2:0];
          p_addr_nxt = g_addr_r[AW-1:0];
          g_addr_nxt = g_addr_r + IDXW'(ROW_BYTES);
          g_cnt_nxt  = g_cnt_r + 4'd1;
        end
        // read data of the previous issue: take the pixel, copy to shadow
        if (p_vld_r) begin
          acc_v[p_b_r] = fb_q[col_lo_r];
          if (fb_q != sh_q) begin
            sh_we = 1'b1;
            if (differ_r != DCW'(0)) begin
              differ_nxt = differ_r - DCW'(1);
            end
          end
        end
        acc_nxt = acc_v;
        if (g_cnt_r == 4'd8) begin
          res_nxt.outcome      = OUT_XFER;
          res_nxt.select1_n    = !(ci_r == CIW'(0));
          res_nxt.select2_n    = !(CONTROLLER_COUNT > 1 && ci_r == CIW'(1));
          res_nxt.is_data      = 1'b1;
          res_nxt.bus_byte     = acc_v;
          res_nxt.last_of_scan = 1'b0;
          if (step_r == STW'(COLUMNS_PER_CONTROLLER + 3)) begin
            step_nxt = STW'(0);
            if (page_r == PGW'(PAGE_COUNT - 1)) begin
              page_nxt = PGW'(0);
              lead_nxt = 1'b0;
              if (ci_r == CIW'(CONTROLLER_COUNT - 1)) begin
                ci_nxt               = CIW'(0);
                scanning_nxt         = 1'b0;
                res_nxt.last_of_scan = 1'b1;
              end else begin
                ci_nxt = ci_r + CIW'(1);
              end
            end else begin
              page_nxt = page_r + PGW'(1);
            end
          end else begin
            step_nxt = step_r + STW'(1);
          end
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        // hand over once the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_r            <= '0;
      refresh_enable_r <= 1'b0;
      scanning_r       <= 1'b0;
      ci_r             <= '0;
      page_r           <= '0;
      step_r           <= '0;
      lead_r           <= 1'b0;
      differ_r         <= '0;
      g_cnt_r          <= '0;
      p_vld_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      clr_r            <= clr_nxt;
      refresh_enable_r <= refresh_enable_nxt;
      scanning_r       <= scanning_nxt;
      ci_r             <= ci_nxt;
      page_r           <= page_nxt;
      step_r           <= step_nxt;
      lead_r           <= lead_nxt;
      differ_r         <= differ_nxt;
      g_cnt_r          <= g_cnt_nxt;
      p_vld_r          <= p_vld_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wr_idx_r   <= wr_idx_nxt;
    wr_val_r   <= wr_val_nxt;
    g_addr_r   <= g_addr_nxt;
    col_lo_r   <= col_lo_nxt;
    acc_r      <= acc_nxt;
    p_b_r      <= p_b_nxt;
    p_addr_r   <= p_addr_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  // framebuffer is never written by a request while a scan runs
  `GLCD_ASSERT_IMP(a_no_frame_write_in_scan, fb_we && state_r != ST_CLEAR, !scanning_r)
  // the differ count never exceeds the framebuffer size
  `GLCD_ASSERT_IMP(a_count_bound, 1'b1, differ_r <= DCW'(FB_SIZE))
  // the final transfer of a scan leaves the engine idle
  `GLCD_ASSERT_NXT(a_last_ends_scan, out_load && res_r.last_of_scan, !scanning_r)
  // an accepted request always moves the sequencer out of idle
  `GLCD_ASSERT_NXT(a_accept_leaves_idle, in_req.valid && in_req.ready, state_r != ST_IDLE)
  // gather never issues more than eight reads
  `GLCD_ASSERT_IMP(a_gather_bound, state_r == ST_GATHER, g_cnt_r <= 4'd8)

endmodule

/* tb/glcd_refresh_checker.sv */
// ---------------------------------------------------------------------------
// glcd refresh checker
// watches the request and result channels, predicts every result of the
// refresh engine from its own framebuffer and sequencer copy, and compares
// ---------------------------------------------------------------------------
module glcd_refresh_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  glcd_in_if   req_ch,
  glcd_out_if  rsp_ch,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import glcd_pkg::*;

  localparam int CONTROLLERS = 2;
  localparam int PAGES       = 8;
  localparam int COLUMNS     = 64;
  localparam int ROW_BYTES   = CONTROLLERS * COLUMNS / 8;
  localparam int FB_BYTES    = ROW_BYTES * PAGES * 8;

  // position within one page of the sequencer
  localparam int STEP_PAGE_CMD  = 0;
  localparam int STEP_NOP_A     = 1;
  localparam int STEP_COL_ADDR  = 2;
  localparam int STEP_NOP_B     = 3;
  localparam int STEP_FIRST_COL = 4;

  logic [7:0]  frame_mem  [FB_BYTES];
  logic [7:0]  shadow_mem [FB_BYTES];
  logic [10:0] dirty_bytes;
  logic        scan_busy;
  logic [2:0]  ctrl_sel;
  logic [3:0]  page_sel;
  logic [7:0]  step_sel;
  logic        lead_sent;
  logic        refresh_on;

  out_item_t expected_results [$];
  int        mismatches = 0;

  function automatic out_item_t no_transfer(input logic [2:0] code);
    out_item_t r;
    r.outcome      = code;
    r.select1_n    = 1'b1;
    r.select2_n    = 1'b1;
    r.is_data      = 1'b0;
    r.bus_byte     = 8'd0;
    r.last_of_scan = 1'b0;
    return r;
  endfunction

  // eight stacked pixels of one column, shadow brought up to date on the way
  function automatic logic [7:0] gather_column_byte(input int col);
    logic [7:0] column;
    int         addr;
    column = 8'd0;
    for (int b = 0; b < 8; b++) begin
      addr = int'(ctrl_sel) * (COLUMNS / 8) + col / 8 + (int'(page_sel) * 8 + b) * ROW_BYTES;
      if (addr < FB_BYTES) begin
        if (frame_mem[addr][col % 8]) column[b] = 1'b1;
        if (shadow_mem[addr] != frame_mem[addr]) begin
          shadow_mem[addr] = frame_mem[addr];
          if (dirty_bytes != 0) dirty_bytes = dirty_bytes - 11'd1;
        end
      end
    end
    return column;
  endfunction

  function automatic out_item_t next_bus_transfer();
    out_item_t x;
    int        col;
    x = no_transfer(OUT_XFER);
    if (ctrl_sel == 0) x.select1_n = 1'b0;
    else if (ctrl_sel == 1) x.select2_n = 1'b0;
    if (!lead_sent) begin
      x.bus_byte = CMD_START;
      lead_sent  = 1'b1;
    end else if (step_sel == STEP_PAGE_CMD) begin
      x.bus_byte = CMD_PAGE | {5'd0, page_sel[2:0]};
      step_sel++;
    end else if (step_sel == STEP_NOP_A || step_sel == STEP_NOP_B) begin
      x.bus_byte = CMD_START;
      step_sel++;
    end else if (step_sel == STEP_COL_ADDR) begin
      x.bus_byte = CMD_ADDR;
      step_sel++;
    end else begin
      col       = int'(step_sel) - STEP_FIRST_COL;
      x.bus_byte = gather_column_byte(col);
      x.is_data = 1'b1;
      step_sel++;
      if (col + 1 >= COLUMNS) begin
        step_sel = 8'd0;
        page_sel++;
        if (page_sel >= PAGES) begin
          page_sel  = 4'd0;
          lead_sent = 1'b0;
          ctrl_sel++;
          if (ctrl_sel >= CONTROLLERS) begin
            ctrl_sel       = 3'd0;
            scan_busy      = 1'b0;
            x.last_of_scan = 1'b1;
          end
        end
      end
    end
    return x;
  endfunction

  function automatic out_item_t predict_panel_result(input in_item_t req);
    out_item_t r;
    logic      was_dirty;
    logic      now_dirty;
    r = no_transfer(OUT_NOTHING);
    case (req.kind)
      KIND_WRITE: begin
        if (scan_busy) begin
          r.outcome = OUT_REFUSED;
        end else if (int'(req.byte_index) < FB_BYTES) begin
          was_dirty = frame_mem[req.byte_index] != shadow_mem[req.byte_index];
          now_dirty = req.write_value != shadow_mem[req.byte_index];
          frame_mem[req.byte_index] = req.write_value;
          if (was_dirty && !now_dirty && dirty_bytes != 0) dirty_bytes = dirty_bytes - 11'd1;
          else if (!was_dirty && now_dirty) dirty_bytes = dirty_bytes + 11'd1;
          r.outcome = OUT_ACCEPTED;
        end
      end
      KIND_REQUEST: begin
        if (!scan_busy && refresh_on && dirty_bytes != 0) begin
          scan_busy = 1'b1;
          ctrl_sel  = 3'd0;
          page_sel  = 4'd0;
          step_sel  = 8'd0;
          lead_sent = 1'b0;
          r.outcome = OUT_STARTED;
        end
      end
      KIND_TICK: begin
        if (scan_busy) r = next_bus_transfer();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int check_field(input string field, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t oldest;
    if (!rst_n) begin
      for (int i = 0; i < FB_BYTES; i++) begin
        frame_mem[i]  = 8'd0;
        shadow_mem[i] = 8'd0;
      end
      dirty_bytes = 11'd0;
      scan_busy   = 1'b0;
      ctrl_sel    = 3'd0;
      page_sel    = 4'd0;
      step_sel    = 8'd0;
      lead_sent   = 1'b0;
      refresh_on  = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) refresh_on = cfg_wdata;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: outcome %0h", rsp_ch.payload.outcome);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          mismatches += check_field("outcome", 8'(oldest.outcome),
                                    8'(rsp_ch.payload.outcome));
          mismatches += check_field("select1_n", 8'(oldest.select1_n),
                                    8'(rsp_ch.payload.select1_n));
          mismatches += check_field("select2_n", 8'(oldest.select2_n),
                                    8'(rsp_ch.payload.select2_n));
          mismatches += check_field("is_data", 8'(oldest.is_data),
                                    8'(rsp_ch.payload.is_data));
          mismatches += check_field("bus_byte", oldest.bus_byte, rsp_ch.payload.bus_byte);
          mismatches += check_field("last_of_scan", 8'(oldest.last_of_scan),
                                    8'(rsp_ch.payload.last_of_scan));
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(predict_panel_result(req_ch.payload));
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

/* tb/glcd_dirty_refresh_scanner_test.sv */
// ---------------------------------------------------------------------------
// glcd dirty refresh scanner test
// drives framebuffer writes, refresh requests and bus ticks with random gaps
// and sink stalls, toggles refresh enable between phases and leaves result
// checking to the refresh checker
// ---------------------------------------------------------------------------
module glcd_dirty_refresh_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import glcd_pkg::*;

  // kind the block has no meaning for
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 700;
  // a whole scan is 2 * (1 + 8 * (4 + 64)) = 1090 ticks, a few spare
  localparam int FULL_SCAN_TICKS = 1100;
  localparam int MAX_GAP         = 10;
  // settle time, sized by the slowest kind of request, column bytes
  localparam int SETTLE_CYCLES   = 40;
  // clearing pass plus several thousand requests at worst-case pace, many times over
  localparam int CYCLE_LIMIT     = 1_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  int fail_count;
  int pending_count;
  int items_sent;
  int full_scans;
  int cycle_count;
  bit src_burst;
  bit sink_burst;

  // recently written bytes, so writes sometimes land on the same byte again
  logic [9:0] recent_index [8];

  glcd_in_if  in_ch ();
  glcd_out_if out_ch ();

  glcd_dirty_refresh_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_ch),
    .out_rsp   (out_ch)
  );

  glcd_refresh_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_ch        (in_ch),
    .rsp_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  // one request: optional gap, then hold valid until the handshake
  task automatic send_request(input logic [1:0] kind, input logic [9:0] index,
                              input logic [7:0] value);
    in_item_t item;
    int       gap;
    item.kind        = kind;
    item.byte_index  = index;
    item.write_value = value;
    // occasionally flip between gap-free bursts and random gaps
    if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.payload <= item;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // framebuffer write with extremes, zero and repeated bytes favored
  task automatic random_write();
    logic [9:0] index;
    logic [7:0] value;
    int         pick;
    pick = $urandom_range(0, 15);
    if (pick < 3) index = recent_index[3'($urandom_range(0, 7))];
    else if (pick == 3) index = 10'd0;
    else if (pick == 4) index = 10'h3FF;
    else index = 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 7);
    // zero often matches the shadow, which pulls the dirty count back down
    if (pick == 0) value = 8'h00;
    else if (pick == 1) value = 8'hFF;
    else value = 8'($urandom_range(0, 255));
    recent_index[3'($urandom_range(0, 7))] = index;
    send_request(KIND_WRITE, index, value);
  endtask

  // anything but a tick: unused kind, request or write
  task automatic noise_item();
    case ($urandom_range(0, 2))
      0: send_request(KIND_UNUSED, 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)));
      1: send_request(KIND_REQUEST, 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)));
      default: random_write();
    endcase
  endtask

  // drop valid and let every expected result drain, then settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_refresh_enable(input logic enable);
    wait_idle();
    cfg_wdata <= enable;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result sink: random stalls per result, with stall-free stretches
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    sink_burst = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL glcd_dirty_refresh_scanner");
    $finish;
  end

  initial begin : stimulus
    int  nwrites;
    int  nticks;
    bit  long_run;
    bit  enable;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    items_sent = 0;
    full_scans = 0;
    src_burst  = 1'b0;
    for (int i = 0; i < 8; i++) recent_index[i] = 10'd0;

    // synchronous reset, once; the block then clears its memories by itself
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // refresh off and nothing dirty: request ignored
    send_request(KIND_REQUEST, 10'd0, 8'd0);
    // tick with no scan running
    send_request(KIND_TICK, 10'd0, 8'd0);
    // unused kind, all other bits high
    send_request(KIND_UNUSED, 10'h3FF, 8'hFF);
    // first and last framebuffer byte, leftmost pixel and full byte
    send_request(KIND_WRITE, 10'd0, 8'h01);
    send_request(KIND_WRITE, 10'h3FF, 8'hFF);
    // dirty a byte, then write its shadow value back: count goes up and down
    send_request(KIND_WRITE, 10'd5, 8'hAA);
    send_request(KIND_WRITE, 10'd5, 8'h00);
    // rightmost pixel of the first byte of the second row
    send_request(KIND_WRITE, 10'd16, 8'h80);
    // dirty but refresh off: request ignored
    send_request(KIND_REQUEST, 10'd0, 8'd0);

    set_refresh_enable(1'b1);
    send_request(KIND_REQUEST, 10'd0, 8'd0);
    // request and write while a scan runs: ignored and refused
    send_request(KIND_REQUEST, 10'd0, 8'd0);
    send_request(KIND_WRITE, 10'd7, 8'h55);
    // lead no-op, page command, no-op, column address, no-op, two column bytes
    repeat (7) send_request(KIND_TICK, 10'd0, 8'd0);

    // refresh off in the middle of a scan: the scan keeps going
    set_refresh_enable(1'b0);
    send_request(KIND_REQUEST, 10'd0, 8'd0);
    repeat (3) send_request(KIND_TICK, 10'd0, 8'd0);

    // ---- random part ----
    // each phase: refresh setting, a batch of writes, a request, then ticks;
    // some tick runs cover a whole scan so that its end is reached
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS || full_scans < 2) begin
      enable = ($urandom_range(0, 3) != 0);
      set_refresh_enable(enable);
      nwrites = $urandom_range(1, 20);
      repeat (nwrites) begin
        if ($urandom_range(0, 11) == 0) send_request(KIND_TICK,
                                                     10'($urandom_range(0, 1023)),
                                                     8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 11) == 0) noise_item();
        else random_write();
      end
      send_request(KIND_REQUEST, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      long_run = ($urandom_range(0, 2) == 0) ||
                 (items_sent >= RANDOM_ITEMS && full_scans < 2);
      nticks = long_run ? FULL_SCAN_TICKS : $urandom_range(1, 150);
      if (long_run && enable) full_scans++;
      repeat (nticks) begin
        // mostly ticks, now and then a request, write or unused kind mid-scan
        if ($urandom_range(0, 39) == 0) noise_item();
        else send_request(KIND_TICK, 10'($urandom_range(0, 1023)),
                          8'($urandom_range(0, 255)));
      end
    end

    // drain and verdict
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS glcd_dirty_refresh_scanner");
    end else begin
      $display("FAIL glcd_dirty_refresh_scanner");
    end
    $finish;
  end

endmodule
